FILE: src/sdeq_pkg.sv
// shared types and codes for the sorted double-ended queue
// no dependencies; used by sdeq_cell and sorted_double_ended_queue_unit
`timescale 1ns / 1ps

package sdeq_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RM_MIN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RM_MAX = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // operation broadcast to every cell in the row
    typedef struct packed {
        logic                      ins;
        logic                      rm_min;
        logic                      rm_max;
        logic signed [VALUE_W-1:0] value;
    } t_cell_cmd;

endpackage

FILE: src/sdeq_cell.sv
// one storage cell of the sorted row: holds a value and its valid flag
// depends on sdeq_pkg
`timescale 1ns / 1ps

module sdeq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sdeq_pkg::t_cell_cmd               i_cmd,
    input  logic signed [sdeq_pkg::VALUE_W-1:0] i_left_val,
    input  logic                              i_left_vld,
    input  logic                              i_left_lt,
    input  logic signed [sdeq_pkg::VALUE_W-1:0] i_right_val,
    input  logic                              i_right_vld,
    output logic signed [sdeq_pkg::VALUE_W-1:0] o_val,
    output logic                              o_vld,
    output logic                              o_lt
);

    logic signed [sdeq_pkg::VALUE_W-1:0] r_val;
    logic signed [sdeq_pkg::VALUE_W-1:0] n_val;
    logic                                r_vld;
    logic                                n_vld;
    logic                                w_lt;

    // entry strictly below the new value stays put on insert
    assign w_lt = r_vld && (r_val < i_cmd.value);

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_cmd.ins) begin
            if (!w_lt) begin
                // first cell not below the value takes it, the rest shift up
                n_val = i_left_lt ? i_cmd.value : i_left_val;
            end
            n_vld = i_left_vld;
        end else if (i_cmd.rm_min) begin
            n_val = i_right_val;
            n_vld = i_right_vld;
        end else if (i_cmd.rm_max) begin
            n_vld = r_vld & i_right_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_vld = r_vld;
    assign o_lt  = w_lt;

endmodule

FILE: src/sorted_double_ended_queue_unit.sv
// top level of the sorted double-ended queue: row of sdeq_cell plus result register
// depends on sdeq_pkg and sdeq_cell
`timescale 1ns / 1ps

// Sorted double-ended priority queue holding up to CAPACITY signed 32-bit values.
// Request channel (s side): tuser carries the mode (insert, remove smallest,
// remove largest), tdata carries the value to insert.
// Result channel (m side): tdata carries the echoed or removed value, tuser the
// status (ok, empty on remove, full on insert). Every request gives one result.
// Values live in a row of cells in ascending order from cell 0; every request
// updates all cells in parallel, each cell comparing its own entry
// with the request value and taking from a neighbour where the row shifts.
// The result is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle while results are taken.
// If the receiver stalls, the result register holds and s_tready drops, so
// no further request is taken until the pending result leaves.
// Reset (synchronous, active low) clears all valid flags: the store is empty.

module sorted_double_ended_queue_unit #(
    parameter int CAPACITY = sdeq_pkg::CAPACITY_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [31:0] value
    input  logic [1:0]  i_s_tuser,  // [1:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [31:0] result_value
    output logic [1:0]  o_m_tuser   // [1:0] status
);

    localparam int VW = sdeq_pkg::VALUE_W;

    logic signed [VW-1:0] w_val [CAPACITY];
    logic                 w_vld [CAPACITY];
    logic                 w_lt  [CAPACITY];
    logic [CAPACITY-1:0]  w_last;

    sdeq_pkg::t_cell_cmd  w_cmd;
    logic                 w_accept;
    logic                 w_empty;
    logic                 w_full;
    logic signed [VW-1:0] w_max;
    logic signed [VW-1:0] n_res;
    logic [sdeq_pkg::STATUS_W-1:0] n_status;

    logic                 r_m_valid;
    logic signed [VW-1:0] r_res;
    logic [sdeq_pkg::STATUS_W-1:0] r_status;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_empty = !w_vld[0];
    assign w_full  = w_vld[CAPACITY-1];

    always_comb begin
        w_cmd.value  = $signed(i_s_tdata);
        w_cmd.ins    = w_accept && (i_s_tuser == sdeq_pkg::MODE_INSERT) && !w_full;
        w_cmd.rm_min = w_accept && (i_s_tuser == sdeq_pkg::MODE_RM_MIN) && !w_empty;
        w_cmd.rm_max = w_accept && (i_s_tuser == sdeq_pkg::MODE_RM_MAX) && !w_empty;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [VW-1:0] w_lv;
            logic                 w_lvd;
            logic                 w_llt;
            logic signed [VW-1:0] w_rv;
            logic                 w_rvd;

            if (g == 0) begin : g_head
                assign w_lv  = w_cmd.value;
                assign w_lvd = 1'b1;
                assign w_llt = 1'b1;
            end else begin : g_mid_l
                assign w_lv  = w_val[g-1];
                assign w_lvd = w_vld[g-1];
                assign w_llt = w_lt[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_rv  = w_val[g];
                assign w_rvd = 1'b0;
                assign w_last[g] = w_vld[g];
            end else begin : g_mid_r
                assign w_rv  = w_val[g+1];
                assign w_rvd = w_vld[g+1];
                assign w_last[g] = w_vld[g] && !w_vld[g+1];
            end

            sdeq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_left_val  (w_lv),
                .i_left_vld  (w_lvd),
                .i_left_lt   (w_llt),
                .i_right_val (w_rv),
                .i_right_vld (w_rvd),
                .o_val       (w_val[g]),
                .o_vld       (w_vld[g]),
                .o_lt        (w_lt[g])
            );
        end
    endgenerate

    // largest value sits in the last valid cell: one-hot and-or select
    always_comb begin
        w_max = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_max = w_max | (w_val[i] & {VW{w_last[i]}});
        end
    end

    always_comb begin
        n_res    = '0;
        n_status = sdeq_pkg::STATUS_OK;
        case (i_s_tuser)
            sdeq_pkg::MODE_INSERT: begin
                if (w_full) begin
                    n_status = sdeq_pkg::STATUS_FULL;
                end else begin
                    n_res = w_cmd.value;
                end
            end
            sdeq_pkg::MODE_RM_MIN: begin
                if (w_empty) begin
                    n_status = sdeq_pkg::STATUS_EMPTY;
                end else begin
                    n_res = w_val[0];
                end
            end
            sdeq_pkg::MODE_RM_MAX: begin
                if (w_empty) begin
                    n_status = sdeq_pkg::STATUS_EMPTY;
                end else begin
                    n_res = w_max;
                end
            end
            default: begin
                n_res    = '0;
                n_status = sdeq_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res    <= n_res;
            r_status <= n_status;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_res;
    assign o_m_tuser  = r_status;

endmodule

FILE: verif/sdeq_checker.sv
// request/result checker for the sorted double-ended queue: keeps its own sorted store
// depends on sdeq_pkg; instantiated by sorted_double_ended_queue_unit_tb beside the block
`timescale 1ns / 1ps

module sdeq_checker #(
    parameter int CAPACITY = sdeq_pkg::CAPACITY_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,  // [31:0] value
    input  logic [1:0]  i_s_tuser,  // [1:0] mode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,  // [31:0] result_value
    input  logic [1:0]  i_m_tuser,  // [1:0] status
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic signed [sdeq_pkg::VALUE_W-1:0] value;
        logic [sdeq_pkg::STATUS_W-1:0]       status;
    } t_queue_result;

    // ascending copy of the store, valid below held_count
    logic signed [sdeq_pkg::VALUE_W-1:0] held_values [CAPACITY];
    int                                  held_count = 0;
    t_queue_result                       expected_results [$];
    int                                  fail_count = 0;

    function automatic t_queue_result apply_queue_op(
        input logic [sdeq_pkg::MODE_W-1:0]         mode,
        input logic signed [sdeq_pkg::VALUE_W-1:0] value
    );
        t_queue_result r;
        int            pos;
        int            i;
        r.value  = '0;
        r.status = sdeq_pkg::STATUS_OK;
        case (mode)
            sdeq_pkg::MODE_INSERT: begin
                if (held_count >= CAPACITY) begin
                    r.status = sdeq_pkg::STATUS_FULL;
                end else begin
                    // lands ahead of any equal entries
                    pos = 0;
                    while (pos < held_count && held_values[pos] < value)
                        pos++;
                    for (i = held_count; i > pos; i--)
                        held_values[i] = held_values[i-1];
                    held_values[pos] = value;
                    held_count++;
                    r.value = value;
                end
            end
            sdeq_pkg::MODE_RM_MIN: begin
                if (held_count == 0) begin
                    r.status = sdeq_pkg::STATUS_EMPTY;
                end else begin
                    r.value = held_values[0];
                    for (i = 1; i < held_count; i++)
                        held_values[i-1] = held_values[i];
                    held_count--;
                end
            end
            sdeq_pkg::MODE_RM_MAX: begin
                if (held_count == 0) begin
                    r.status = sdeq_pkg::STATUS_EMPTY;
                end else begin
                    r.value = held_values[held_count-1];
                    held_count--;
                end
            end
            default: begin
                // unused mode: zero result, store untouched
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_queue_result want;
        if (!i_rst_n) begin
            held_count = 0;
            expected_results.delete();
        end else begin
            // a result taken on this edge always belongs to an older request
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request waiting: result_value %0d status %0d",
                           $signed(i_m_tdata), i_m_tuser);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_m_tdata !== want.value) begin
                        $error("result_value: expected %0d, actual %0d",
                               want.value, $signed(i_m_tdata));
                        fail_count++;
                    end
                    if (i_m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_m_tuser);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(apply_queue_op(i_s_tuser, i_s_tdata));
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

FILE: verif/sorted_double_ended_queue_unit_tb.sv
// top of the sorted double-ended queue testbench: clock, reset, request and stall stimulus
// depends on sdeq_pkg, sdeq_checker and sorted_double_ended_queue_unit
`timescale 1ns / 1ps

module sorted_double_ended_queue_unit_tb;

    localparam int CAPACITY    = sdeq_pkg::CAPACITY_DEFAULT;
    localparam int RANDOM_REQS = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [sdeq_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED
    } t_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          burst_left  = 0;
    logic [31:0] last_inserted = '0;

    sorted_double_ended_queue_unit #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    sdeq_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: runs of steady, loose, tight and near-blocked acceptance
    initial begin
        int style;
        int span;
        i_m_tready <= 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(4, 40);
            repeat (span) begin
                @(negedge i_clk);
                case (style)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= ($urandom_range(0, 9) < 7);
                    2:       i_m_tready <= ($urandom_range(0, 9) < 3);
                    default: i_m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // one request, preceded by a gap when the current burst has run out
    task automatic send_request(input logic [sdeq_pkg::MODE_W-1:0] mode,
                                input logic [31:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= $urandom;
                i_s_tuser  <= 2'($urandom);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (mode == sdeq_pkg::MODE_INSERT)
            last_inserted = value;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            5, 6:    return $urandom_range(0, 15) - 8;
            7:       return 32'h8000_0000 + $urandom_range(0, 3);
            8:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            9:       return last_inserted;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_phase                        phase;
        int                            phase_left;
        int                            pick;
        logic [sdeq_pkg::MODE_W-1:0]   mode;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, unused mode, extremes and duplicates, then a full store and removals at both ends
        send_request(sdeq_pkg::MODE_RM_MIN, $urandom);
        send_request(sdeq_pkg::MODE_RM_MAX, $urandom);
        send_request(MODE_UNUSED, $urandom);
        send_request(sdeq_pkg::MODE_INSERT, 32'h7FFF_FFFF);
        send_request(sdeq_pkg::MODE_INSERT, 32'h8000_0000);
        send_request(sdeq_pkg::MODE_INSERT, 32'h0000_0000);
        send_request(sdeq_pkg::MODE_INSERT, 32'hFFFF_FFFF);
        send_request(sdeq_pkg::MODE_INSERT, 32'h0000_0001);
        send_request(sdeq_pkg::MODE_INSERT, 32'hFFFF_FFFF);
        send_request(sdeq_pkg::MODE_INSERT, 32'h0000_0000);
        repeat (CAPACITY - 7)
            send_request(sdeq_pkg::MODE_INSERT, $urandom);
        send_request(sdeq_pkg::MODE_INSERT, $urandom);
        send_request(sdeq_pkg::MODE_RM_MIN, $urandom);
        send_request(sdeq_pkg::MODE_RM_MAX, $urandom);
        send_request(sdeq_pkg::MODE_RM_MIN, $urandom);
        send_request(sdeq_pkg::MODE_RM_MAX, $urandom);
        send_request(MODE_UNUSED, $urandom);

        // phases lean towards filling or draining so both ends are hit often
        phase_left = 0;
        phase      = PHASE_MIXED;
        repeat (RANDOM_REQS) begin
            if (phase_left == 0) begin
                phase      = t_phase'($urandom_range(0, 2));
                phase_left = $urandom_range(20, 50);
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                mode = MODE_UNUSED;
            else if ((phase == PHASE_FILL && pick < 80) || (phase == PHASE_DRAIN && pick < 20)
                     || (phase == PHASE_MIXED && pick < 50))
                mode = sdeq_pkg::MODE_INSERT;
            else
                mode = $urandom_range(0, 1) ? sdeq_pkg::MODE_RM_MIN : sdeq_pkg::MODE_RM_MAX;
            send_request(mode, (mode == sdeq_pkg::MODE_INSERT) ? pick_value() : $urandom);
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
